// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types, constants and helpers of the positional sequence store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pss_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W       = 5;
  localparam int unsigned CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REMOVE_AT = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] removed_value;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
  } out_t;

  // Fit an input word into a cell: sign-extend or truncate.
  function automatic word_t to_cell(logic signed [31:0] v);
    return VALUE_WIDTH'(v);
  endfunction

  // Read a cell out as a 32-bit word: sign-extend or truncate.
  function automatic logic signed [31:0] to_word(word_t c);
    return 32'(c);
  endfunction

endpackage

// File: sv/positional_sequence_store.sv
// ----------------------------------------------------------------------------
// positional_sequence_store
// The input register takes the command at the transfer edge; the result
// register takes its result when the held command advances, which a stall
// on the result side can hold off. Throughput: one command per cycle while
// results are taken, set by the cell row that shifts in a single pass. Reset
// clears the entry count and both valid flags; the cells hold no reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_sequence_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pss_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pss_pkg::out_t out_data_o
);
  import pss_pkg::*;

  // Input register: holds one command until the cell row can take it.
  logic in_valid_q;
  in_t  in_q;

  // Result register: parts the result side from the command side.
  logic out_valid_q;
  out_t out_q, out_d;

  // Cell row and fill count.
  word_t            cell_q [CAPACITY];
  word_t            cell_d [CAPACITY];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic advance;

  // Advance the held command when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Command decode and cell shift.
  logic             is_ins, is_rem, full, empty;
  logic [CNT_W-1:0] ins_at, rem_at, tail_at;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  word_t            ins_word, rem_word, tail_word;
  status_e          status;

  always_comb begin
    pos_ext  = CMP_W'(in_q.position);
    cnt_ext  = CMP_W'(cnt_q);
    full     = (cnt_q == CNT_W'(CAPACITY));
    empty    = (cnt_q == '0);
    ins_word = to_cell(in_q.value);
    is_ins   = 1'b0;
    is_rem   = 1'b0;
    ins_at   = '0;
    rem_at   = '0;

    case (in_q.opcode)
      OP_ADD_FRONT: begin
        is_ins = 1'b1;
      end
      OP_ADD_BACK: begin
        is_ins = 1'b1;
        ins_at = cnt_q;
      end
      OP_INSERT_AT: begin
        is_ins = 1'b1;
        // Clamp a position past the end to just after the last entry.
        ins_at = (pos_ext > cnt_ext) ? cnt_q : CNT_W'(pos_ext);
      end
      OP_REM_FRONT: begin
        is_rem = 1'b1;
      end
      OP_REM_BACK: begin
        is_rem = 1'b1;
        rem_at = cnt_q - 1'b1;
      end
      OP_REMOVE_AT: begin
        is_rem = 1'b1;
        // Clamp a position past the end to the last entry.
        rem_at = (pos_ext >= cnt_ext) ? cnt_q - 1'b1 : CNT_W'(pos_ext);
      end
      default: begin
        // Unused codes change nothing and report done.
      end
    endcase

    // Pick the removed cell by one-hot select over the row.
    rem_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == rem_at) begin
        rem_word = rem_word | cell_q[i];
      end
    end

    status = ST_DONE;
    cnt_d  = cnt_q;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
    end

    if (is_ins && full) begin
      status = ST_FULL;
    end else if (is_rem && empty) begin
      status = ST_EMPTY;
    end else if (is_ins) begin
      // Shift cells at and behind the insert point one place back.
      for (int i = 0; i < CAPACITY; i++) begin
        if (CNT_W'(i) == ins_at) begin
          cell_d[i] = ins_word;
        end else if (i > 0 && CNT_W'(i) > ins_at) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end
      cnt_d = cnt_q + 1'b1;
    end else if (is_rem) begin
      // Close the gap: cells behind the removal point move one place forward.
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (CNT_W'(i) >= rem_at) begin
          cell_d[i] = cell_q[i + 1];
        end
      end
      cnt_d = cnt_q - 1'b1;
    end

    // Tail of the updated row.
    tail_at   = cnt_d - 1'b1;
    tail_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == tail_at) begin
        tail_word = tail_word | cell_d[i];
      end
    end

    out_d.status        = status;
    out_d.entry_count   = 5'(cnt_d);
    out_d.removed_value = (is_rem && !empty) ? to_word(rem_word) : 32'sd0;
    out_d.head_value    = (cnt_d != '0) ? to_word(cell_d[0]) : 32'sd0;
    out_d.tail_value    = (cnt_d != '0) ? to_word(tail_word) : 32'sd0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
      for (int i = 0; i < CAPACITY; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni,
    cnt_q > CNT_W'(CAPACITY), "count beyond capacity")
  `ASSERT_CLK(a_cnt_matches, clk_i, rst_ni,
    out_valid_q |-> (out_q.entry_count == 5'(cnt_q)),
    "result count differs from store count")
  `ASSERT_CLK(a_adv_result, clk_i, rst_ni,
    advance |=> out_valid_q, "command advanced without a result")
  `ASSERT_CLK(a_rem_step, clk_i, rst_ni,
    (advance && is_rem && !empty) |=> (cnt_q == $past(cnt_q) - 1'b1),
    "removal did not drop one entry")

endmodule
